@@ hdl/gshare_branch_predictor_unit_assert.svh @@
// ----------------------------------------------------------------------------
// gshare branch predictor assertion macros
// Shared property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GSHARE_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define GBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gbp_pkg.sv @@
// ----------------------------------------------------------------------------
// gbp_pkg
// Sizes, codes and controller/datapath handshake types of the gshare predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

  // table geometry; the target buffer depth is a power of two
  localparam int unsigned TARGET_ENTRIES = 256;
  localparam int unsigned HISTORY_BITS   = 8;
  localparam int unsigned PHT_ENTRIES    = 1 << HISTORY_BITS;
  localparam int unsigned PHT_IDX_W      = HISTORY_BITS;
  localparam int unsigned BTB_IDX_W      = $clog2(TARGET_ENTRIES);

  // counter and address constants
  localparam logic [1:0]  CNT_MAX         = 2'd3;
  localparam logic [1:0]  CNT_MIN         = 2'd0;
  localparam logic [1:0]  TAKEN_THRESHOLD = 2'd2;
  localparam logic [31:0] INSN_BYTES      = 32'd4;

  // operation codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input beat and start the table reads
    logic commit;    // write counter, target, valid bits and history
    logic load;      // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_update;
  } sts_t;

endpackage

@@ hdl/gbp_in_if.sv @@
// ----------------------------------------------------------------------------
// gbp_in_if
// Request channel: predict or update beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] pc;
  logic [31:0] resolved_next_pc;
  logic        taken;

  modport source (output valid, output op, output pc, output resolved_next_pc,
                  output taken, input ready);
  modport sink   (input valid, input op, input pc, input resolved_next_pc,
                  input taken, output ready);
endinterface

@@ hdl/gbp_out_if.sv @@
// ----------------------------------------------------------------------------
// gbp_out_if
// Result channel: predicted next PC and direction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] predicted_pc;
  logic        predicted_taken;

  modport source (output valid, output predicted_pc, output predicted_taken,
                  input ready);
  modport sink   (input valid, input predicted_pc, input predicted_taken,
                  output ready);
endinterface

@@ hdl/gshare_branch_predictor_unit.sv @@
// ----------------------------------------------------------------------------
// gshare_branch_predictor_unit
// Gshare direction predictor with a direct-mapped branch target buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one beat per request: op selects predict or update, pc is
//   the byte address, resolved_next_pc and taken matter only on update.
//   out_o carries one beat per predict: predicted_pc and predicted_taken.
//   An update returns nothing; it trains the counter chosen with the
//   history as it stood before the update, writes the target and shifts
//   the outcome into the history.
// Sequence:
//   every request first reads the counter and target memories, then
//   commits or loads the result register. A new request is accepted only
//   once the last one is done; a prediction is loaded into the result
//   register when that register is free and appears on out_o from it.
// Reset:
//   history, counter valid bits and target valid bits clear at once; all
//   counters read as strongly not taken and no target is valid.
// Stall:
//   a held result does not block the next request; only a second
//   prediction waits, with in_i not ready, until the result is taken.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  gbp_in_if.sink   in_i,
  gbp_out_if.source out_o
);

  gbp_pkg::cmd_t cmd;
  gbp_pkg::sts_t sts;

  gbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbp_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .op_i               (in_i.op),
    .pc_i               (in_i.pc),
    .resolved_next_pc_i (in_i.resolved_next_pc),
    .taken_i            (in_i.taken),
    .predicted_pc_o     (out_o.predicted_pc),
    .predicted_taken_o  (out_o.predicted_taken)
  );

endmodule

@@ hdl/gbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbp_ctrl
// Two-state sequencer: capture a beat, then commit an update or hand a
// prediction to the result register once that register is free.
// ----------------------------------------------------------------------------
module gbp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gbp_pkg::sts_t sts_i,
  output gbp_pkg::cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_update) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end else if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/gbp_datapath.sv @@
// ----------------------------------------------------------------------------
// gbp_datapath
// Global history, pattern counter table, target buffer and result register.
// ----------------------------------------------------------------------------
module gbp_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gbp_pkg::cmd_t cmd_i,
  output gbp_pkg::sts_t sts_o,
  input  logic          op_i,
  input  logic [31:0]   pc_i,
  input  logic [31:0]   resolved_next_pc_i,
  input  logic          taken_i,
  output logic [31:0]   predicted_pc_o,
  output logic          predicted_taken_o
);

  // tables: counters and targets in memories, valid bits in flops
  logic [1:0]  pht_mem [gbp_pkg::PHT_ENTRIES];
  logic [31:0] btb_mem [gbp_pkg::TARGET_ENTRIES];
  logic [gbp_pkg::PHT_ENTRIES-1:0]    pht_vld_q;
  logic [gbp_pkg::TARGET_ENTRIES-1:0] btb_vld_q;
  logic [gbp_pkg::PHT_IDX_W-1:0]      hist_q;

  // captured beat
  logic                          op_q;
  logic [31:0]                   pc_q;
  logic [31:0]                   next_pc_q;
  logic                          taken_q;
  logic [gbp_pkg::PHT_IDX_W-1:0] pht_idx_q;
  logic [gbp_pkg::BTB_IDX_W-1:0] btb_idx_q;

  // registered table reads
  logic [1:0]  cnt_rd_q;
  logic        cnt_vld_q;
  logic [31:0] tgt_rd_q;
  logic        tgt_vld_q;

  // result register
  logic [31:0] pred_pc_q;
  logic        pred_taken_q;

  logic [gbp_pkg::PHT_IDX_W-1:0] pht_idx;
  logic [gbp_pkg::BTB_IDX_W-1:0] btb_idx;
  logic [1:0]                    cnt;
  logic [1:0]                    cnt_next;
  logic                          pred_taken;
  logic [31:0]                   pred_pc;

  // index from the word address, counter index hashed with history
  assign pht_idx = pc_i[2 +: gbp_pkg::PHT_IDX_W] ^ hist_q;
  assign btb_idx = pc_i[2 +: gbp_pkg::BTB_IDX_W];

  // capture the beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      pc_q      <= pc_i;
      next_pc_q <= resolved_next_pc_i;
      taken_q   <= taken_i;
      pht_idx_q <= pht_idx;
      btb_idx_q <= btb_idx;
      cnt_vld_q <= pht_vld_q[pht_idx];
      tgt_vld_q <= btb_vld_q[btb_idx];
    end
  end

  // counter memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cnt_rd_q <= pht_mem[pht_idx];
    end
    if (cmd_i.commit) begin
      pht_mem[pht_idx_q] <= cnt_next;
    end
  end

  // target memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tgt_rd_q <= btb_mem[btb_idx];
    end
    if (cmd_i.commit) begin
      btb_mem[btb_idx_q] <= next_pc_q;
    end
  end

  // counter value, unwritten entries read as strongly not taken
  assign cnt        = cnt_vld_q ? cnt_rd_q : gbp_pkg::CNT_MIN;
  assign pred_taken = (cnt >= gbp_pkg::TAKEN_THRESHOLD);
  assign pred_pc    = (pred_taken && tgt_vld_q) ? tgt_rd_q : pc_q + gbp_pkg::INSN_BYTES;

  // saturating step toward the outcome
  always_comb begin
    cnt_next = cnt;
    if (taken_q) begin
      if (cnt != gbp_pkg::CNT_MAX) begin
        cnt_next = cnt + 2'd1;
      end
    end else begin
      if (cnt != gbp_pkg::CNT_MIN) begin
        cnt_next = cnt - 2'd1;
      end
    end
  end

  // valid bits and global history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pht_vld_q <= '0;
      btb_vld_q <= '0;
      hist_q    <= '0;
    end else if (cmd_i.commit) begin
      pht_vld_q[pht_idx_q] <= 1'b1;
      btb_vld_q[btb_idx_q] <= 1'b1;
      hist_q               <= gbp_pkg::PHT_IDX_W'({hist_q, taken_q});
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pred_pc_q    <= pred_pc;
      pred_taken_q <= pred_taken;
    end
  end

  assign sts_o.is_update    = (op_q == gbp_pkg::OP_UPDATE);
  assign predicted_pc_o     = pred_pc_q;
  assign predicted_taken_o  = pred_taken_q;

endmodule

@@ hdl/gbp_checker.sv @@
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level properties of the predictor, bound to the top level.
// ----------------------------------------------------------------------------
`include "gshare_branch_predictor_unit_assert.svh"

module gbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] predicted_pc_i,
  input logic        predicted_taken_i
);

  logic in_beat;

  assign in_beat = in_valid_i && in_ready_i;

  // a stalled result beat holds
  `GBP_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(predicted_pc_i) && $stable(predicted_taken_i),
    "result beat changed while stalled")

  // one request at a time: no beat right after an accepted one
  `GBP_ASSERT_NXT(a_one_in_flight, in_beat, !in_ready_i,
    "input accepted on consecutive cycles")

  // an update never raises a result
  `GBP_ASSERT_IMP(a_update_silent, in_beat && op_i == gbp_pkg::OP_UPDATE,
    ##2 !$rose(out_valid_i), "update produced a result beat")

  // a predict into an empty result slot produces a result beat
  `GBP_ASSERT_IMP(a_predict_result, in_beat && op_i == gbp_pkg::OP_PREDICT && !out_valid_i,
    ##2 out_valid_i, "predict produced no result beat")

endmodule

bind gshare_branch_predictor_unit gbp_checker u_gbp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .op_i              (in_i.op),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .predicted_pc_i    (out_o.predicted_pc),
  .predicted_taken_i (out_o.predicted_taken)
);
